/* rtl/core/ordered_list_deque_search_core_assert.svh */
// Assertion macros for the ordered list deque core
`ifndef ORDERED_LIST_DEQUE_SEARCH_CORE_ASSERT_SVH
`define ORDERED_LIST_DEQUE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define OLDS_ASSERT_NOW(label, clk, rst, cond_a, cond_b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define OLDS_ASSERT_NEXT(label, clk, rst, cond_a, cond_b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
      else $error(msg);

`endif

/* rtl/core/olds_pkg.sv */
`timescale 1ns / 1ps

package olds_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int ValueWidth    = 32;
   localparam int KindWidth     = 3;
   localparam int StatusWidth   = 2;
   localparam int CountOutWidth = 5;

   typedef enum logic [KindWidth-1:0] {
      KIND_PUSH_HEAD = 3'd0,
      KIND_PUSH_TAIL = 3'd1,
      KIND_POP_HEAD  = 3'd2,
      KIND_POP_TAIL  = 3'd3,
      KIND_DELETE    = 3'd4,
      KIND_SEARCH    = 3'd5
   } kind_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // What every cell does in the coming cycle
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH_HEAD,
      CMD_PUSH_TAIL,
      CMD_POP_HEAD,
      CMD_POP_TAIL,
      CMD_DELETE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type                  cmd;
      logic signed [ValueWidth-1:0]  key;
   } cell_ctl_type;

   typedef struct packed {
      logic [KindWidth-1:0]          kind;
      logic signed [ValueWidth-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0]  removed_value;
      logic [StatusWidth-1:0]        status;
      logic [CountOutWidth-1:0]      entry_count;
   } rsp_type;

endpackage

/* rtl/core/ordered_list_deque_search_core.sv */
`timescale 1ns / 1ps

// Ordered list deque with search.
// Input channel req_*: one transaction carries a kind (push head, push tail,
// pop head, pop tail, delete first match, search) and a 32-bit value.
// Result channel rsp_*: exactly one transaction per request, carrying the
// popped value (zero otherwise), a status code and the entry count after
// the operation.
// The list lives in a row of DEPTH cells; every cell compares its entry
// with the key and shifts toward or away from the head in the same cycle,
// so a request completes in the cycle it is accepted, and its result sits in the
// output register on the next edge.
// Throughput: one transaction per cycle while the result side keeps up.
// When rsp_stall holds a waiting result, req_stall rises until it is taken;
// the held result never changes.
// Reset (synchronous) empties the list and drops any waiting result.
`include "ordered_list_deque_search_core_assert.svh"

module ordered_list_deque_search_core #(
   parameter int DEPTH = olds_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  olds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output olds_pkg::rsp_type rsp_data
);

   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam int ExtWidth   = CountWidth + olds_pkg::CountOutWidth;

   logic signed [olds_pkg::ValueWidth-1:0] val_vec [DEPTH];
   logic [DEPTH-1:0]                       occ_vec;
   logic [DEPTH:0]                         hit_vec;

   olds_pkg::cell_ctl_type ctl;
   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   found;

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   olds_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic signed [olds_pkg::ValueWidth-1:0] tail_value;
   logic signed [olds_pkg::ValueWidth-1:0] removed;
   olds_pkg::status_type                   status;
   logic [ExtWidth-1:0]                    count_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = occ_vec[DEPTH-1];
   assign empty     = !occ_vec[0];
   assign found     = hit_vec[DEPTH];
   assign hit_vec[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : gen_cell
         logic signed [olds_pkg::ValueWidth-1:0] lv, rv;
         logic                                   lo, ro;
         if (g == 0) begin : gen_head
            assign lv = ctl.key;
            assign lo = 1'b1;
         end else begin : gen_mid_left
            assign lv = val_vec[g-1];
            assign lo = occ_vec[g-1];
         end
         if (g == DEPTH - 1) begin : gen_tail
            assign rv = '0;
            assign ro = 1'b0;
         end else begin : gen_mid_right
            assign rv = val_vec[g+1];
            assign ro = occ_vec[g+1];
         end
         olds_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_value  (lv),
            .left_occ    (lo),
            .right_value (rv),
            .right_occ   (ro),
            .hit_in      (hit_vec[g]),
            .hit_out     (hit_vec[g+1]),
            .value_out   (val_vec[g]),
            .occ_out     (occ_vec[g])
         );
      end
   endgenerate

   // One-hot select of the last occupied cell
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (occ_vec[i] && ((i == DEPTH - 1) || !occ_vec[(i + 1) % DEPTH])) begin
            tail_value = tail_value | val_vec[i];
         end
      end
   end

   always_comb begin
      ctl.key  = req_data.value;
      ctl.cmd  = olds_pkg::CMD_HOLD;
      count_in = count_ff;
      removed  = '0;
      status   = olds_pkg::STATUS_OK;
      unique case (req_data.kind) inside
         olds_pkg::KIND_PUSH_HEAD, olds_pkg::KIND_PUSH_TAIL: begin
            if (full) begin
               status = olds_pkg::STATUS_FULL;
            end else begin
               ctl.cmd  = (req_data.kind == olds_pkg::KIND_PUSH_HEAD) ?
                          olds_pkg::CMD_PUSH_HEAD : olds_pkg::CMD_PUSH_TAIL;
               count_in = count_ff + CountWidth'(1);
            end
         end
         olds_pkg::KIND_POP_HEAD, olds_pkg::KIND_POP_TAIL: begin
            if (empty) begin
               status = olds_pkg::STATUS_EMPTY;
            end else if (req_data.kind == olds_pkg::KIND_POP_HEAD) begin
               ctl.cmd  = olds_pkg::CMD_POP_HEAD;
               removed  = val_vec[0];
               count_in = count_ff - CountWidth'(1);
            end else begin
               ctl.cmd  = olds_pkg::CMD_POP_TAIL;
               removed  = tail_value;
               count_in = count_ff - CountWidth'(1);
            end
         end
         olds_pkg::KIND_DELETE: begin
            if (!found) begin
               status = olds_pkg::STATUS_NOT_FOUND;
            end else begin
               ctl.cmd  = olds_pkg::CMD_DELETE;
               count_in = count_ff - CountWidth'(1);
            end
         end
         olds_pkg::KIND_SEARCH: begin
            if (!found) begin
               status = olds_pkg::STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         ctl.cmd  = olds_pkg::CMD_HOLD;
         count_in = count_ff;
      end
   end

   assign count_ext = ExtWidth'(count_in);

   always_comb begin
      rsp_data_in               = rsp_data_ff;
      rsp_data_in.removed_value = removed;
      rsp_data_in.status        = status;
      rsp_data_in.entry_count   = count_ext[olds_pkg::CountOutWidth-1:0];
      rsp_valid_in              = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `OLDS_ASSERT_NOW(a_head_matches_count, clock, reset, 1'b1, occ_vec[0] == (count_ff != '0), "head valid bit disagrees with count")
   `OLDS_ASSERT_NOW(a_tail_matches_count, clock, reset, 1'b1, occ_vec[DEPTH-1] == (count_ff == CountWidth'(DEPTH)), "tail valid bit disagrees with count")
   `OLDS_ASSERT_NOW(a_stall_needs_result, clock, reset, req_stall, rsp_valid_ff, "input stalled with no result waiting")
   `OLDS_ASSERT_NEXT(a_push_grows, clock, reset, accept && (ctl.cmd == olds_pkg::CMD_PUSH_HEAD || ctl.cmd == olds_pkg::CMD_PUSH_TAIL), count_ff == $past(count_ff) + CountWidth'(1), "push did not grow the list")

endmodule

/* rtl/core/olds_cell.sv */
`timescale 1ns / 1ps

module olds_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  olds_pkg::cell_ctl_type                 ctl,
   input  logic signed [olds_pkg::ValueWidth-1:0] left_value,
   input  logic                                   left_occ,
   input  logic signed [olds_pkg::ValueWidth-1:0] right_value,
   input  logic                                   right_occ,
   input  logic                                   hit_in,
   output logic                                   hit_out,
   output logic signed [olds_pkg::ValueWidth-1:0] value_out,
   output logic                                   occ_out
);

   logic signed [olds_pkg::ValueWidth-1:0] value_ff, value_in;
   logic                                   occ_ff, occ_in;
   logic                                   match;

   assign match     = occ_ff && (value_ff == ctl.key);
   // hit ripples toward the tail: set from the first matching cell onward
   assign hit_out   = hit_in || match;
   assign value_out = value_ff;
   assign occ_out   = occ_ff;

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      unique case (ctl.cmd)
         olds_pkg::CMD_PUSH_HEAD: begin
            value_in = left_value;
            occ_in   = left_occ;
         end
         olds_pkg::CMD_PUSH_TAIL: begin
            if (!occ_ff && left_occ) begin
               value_in = ctl.key;
               occ_in   = 1'b1;
            end
         end
         olds_pkg::CMD_POP_HEAD: begin
            value_in = right_value;
            occ_in   = right_occ;
         end
         olds_pkg::CMD_POP_TAIL: begin
            occ_in = right_occ;
         end
         olds_pkg::CMD_DELETE: begin
            if (hit_out) begin
               value_in = right_value;
               occ_in   = right_occ;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

/* test/ordered_list_deque_search_core_test.sv */
`timescale 1ns / 1ps

module ordered_list_deque_search_core_test;

   localparam int LIST_DEPTH  = olds_pkg::DEFAULT_DEPTH;
   localparam int CYCLE_LIMIT = 300000;

   // kind codes the block treats as no-ops
   localparam logic [olds_pkg::KindWidth-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [olds_pkg::KindWidth-1:0] KIND_SPARE_B = 3'd7;

   localparam int STYLE_GROW   = 0;
   localparam int STYLE_SHRINK = 1;
   localparam int STYLE_LOOKUP = 2;
   localparam int STYLE_MIXED  = 3;

   class deque_scoreboard;
      logic [olds_pkg::ValueWidth-1:0] contents[$];
      olds_pkg::rsp_type               expected_q[$];
      int                              errors = 0;

      function void note_request(olds_pkg::req_type r);
         olds_pkg::rsp_type want;
         int                hit;
         want.removed_value = '0;
         want.status        = olds_pkg::STATUS_OK;
         hit                = -1;
         for (int i = 0; i < contents.size(); i++) begin
            if (hit < 0 && contents[i] == r.value) hit = i;
         end
         case (r.kind)
            olds_pkg::KIND_PUSH_HEAD: begin
               if (contents.size() >= LIST_DEPTH) want.status = olds_pkg::STATUS_FULL;
               else contents.push_front(r.value);
            end
            olds_pkg::KIND_PUSH_TAIL: begin
               if (contents.size() >= LIST_DEPTH) want.status = olds_pkg::STATUS_FULL;
               else contents.push_back(r.value);
            end
            olds_pkg::KIND_POP_HEAD: begin
               if (contents.size() == 0) want.status = olds_pkg::STATUS_EMPTY;
               else want.removed_value = contents.pop_front();
            end
            olds_pkg::KIND_POP_TAIL: begin
               if (contents.size() == 0) want.status = olds_pkg::STATUS_EMPTY;
               else want.removed_value = contents.pop_back();
            end
            olds_pkg::KIND_DELETE: begin
               if (hit < 0) want.status = olds_pkg::STATUS_NOT_FOUND;
               else contents.delete(hit);
            end
            olds_pkg::KIND_SEARCH: begin
               if (hit < 0) want.status = olds_pkg::STATUS_NOT_FOUND;
            end
            default: ;
         endcase
         want.entry_count = olds_pkg::CountOutWidth'(contents.size());
         expected_q.push_back(want);
      endfunction

      function void check_result(olds_pkg::rsp_type got);
         olds_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result transaction with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, actual %0d",
                   want.removed_value, got.removed_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, got.entry_count);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   olds_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   olds_pkg::rsp_type rsp_data;

   deque_scoreboard                 board;
   int                              idle_mode  = 1;
   int                              stall_left = 0;
   int                              cycle_count;
   logic [olds_pkg::ValueWidth-1:0] value_pool[6];

   ordered_list_deque_search_core #(.DEPTH(LIST_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly back-to-back, some short gaps, rare long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_mode == 0) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // result side: check accepted transactions, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = pick_gap();
      end
   end

   task automatic send_item(input logic [olds_pkg::KindWidth-1:0] kind,
                            input logic [olds_pkg::ValueWidth-1:0] value);
      olds_pkg::req_type item;
      int                gap;
      item.kind  = kind;
      item.value = value;
      gap        = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [olds_pkg::KindWidth-1:0] pick_kind(int style);
      int r;
      int push_share;
      int pop_share;
      r = $urandom_range(0, 99);
      if (r < 3) return (r == 0) ? KIND_SPARE_A : KIND_SPARE_B;
      case (style)
         STYLE_GROW:   begin push_share = 70; pop_share = 10; end
         STYLE_SHRINK: begin push_share = 20; pop_share = 50; end
         STYLE_LOOKUP: begin push_share = 30; pop_share = 20; end
         default:      begin push_share = 40; pop_share = 30; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_share)
         return $urandom_range(0, 1) ? olds_pkg::KIND_PUSH_HEAD : olds_pkg::KIND_PUSH_TAIL;
      if (r < push_share + pop_share)
         return $urandom_range(0, 1) ? olds_pkg::KIND_POP_HEAD : olds_pkg::KIND_POP_TAIL;
      return $urandom_range(0, 1) ? olds_pkg::KIND_DELETE : olds_pkg::KIND_SEARCH;
   endfunction

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ordered_list_deque_search_core_test failed");
      $finish;
   end

   initial begin
      int style;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corner cases
      send_item(olds_pkg::KIND_POP_HEAD, 32'h0000_0000);
      send_item(olds_pkg::KIND_POP_TAIL, 32'hFFFF_FFFF);
      send_item(olds_pkg::KIND_DELETE,   32'h0000_0000);
      send_item(olds_pkg::KIND_SEARCH,   32'h0000_0000);
      // extreme values, with a duplicate to check first-match delete
      send_item(olds_pkg::KIND_PUSH_HEAD, 32'h7FFF_FFFF);
      send_item(olds_pkg::KIND_PUSH_TAIL, 32'h8000_0000);
      send_item(olds_pkg::KIND_PUSH_HEAD, 32'h0000_0000);
      send_item(olds_pkg::KIND_PUSH_TAIL, 32'hFFFF_FFFF);
      send_item(olds_pkg::KIND_PUSH_TAIL, 32'h8000_0000);
      send_item(olds_pkg::KIND_SEARCH,    32'h8000_0000);
      send_item(olds_pkg::KIND_SEARCH,    32'h0001_2345);
      send_item(olds_pkg::KIND_DELETE,    32'h8000_0000);
      send_item(olds_pkg::KIND_SEARCH,    32'h8000_0000);
      send_item(KIND_SPARE_A,             32'h8000_0000);
      send_item(KIND_SPARE_B,             32'hFFFF_FFFF);
      send_item(olds_pkg::KIND_POP_HEAD,  32'h0000_0000);
      send_item(olds_pkg::KIND_POP_TAIL,  32'h0000_0000);
      send_item(olds_pkg::KIND_DELETE,    32'h0000_0005);
      send_item(olds_pkg::KIND_POP_HEAD,  32'h0000_0000);
      send_item(olds_pkg::KIND_POP_HEAD,  32'h0000_0000);
      send_item(olds_pkg::KIND_POP_TAIL,  32'h0000_0000);
      drain_results();

      // grow phases run the list into full, shrink phases back to empty
      for (int p = 0; p < 10; p++) begin
         style     = p % 4;
         idle_mode = (p % 3 == 2) ? 0 : 1;
         foreach (value_pool[i]) value_pool[i] = $urandom;
         if (p % 2 == 1) begin
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7FFF_FFFF;
         end
         for (int n = 0; n < 60; n++) begin
            send_item(pick_kind(style),
                      ($urandom_range(0, 3) == 0) ? $urandom
                                                  : value_pool[$urandom_range(0, 5)]);
         end
         if (p % 2 == 1) drain_results();
      end

      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("ordered_list_deque_search_core_test passed");
      else
         $display("ordered_list_deque_search_core_test failed");
      $finish;
   end

endmodule
